>>> sv/sedg_pkg.sv
package sedg_pkg;

    localparam int LINE_MAX = 256;
    localparam int COORD_W  = 8;
    localparam int DIM_W    = 9;
    localparam int VAL_W    = 17;
    localparam int ENT_W    = 18;
    localparam int NUM_W    = 19;
    localparam int DEN_W    = 10;
    localparam int PROD_W   = 30;

    localparam logic [VAL_W-1:0] VAL_MAX = 17'h1FFFF;
    localparam logic [ENT_W-1:0] ENT_INF = 18'h20000;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_COMPUTE = 2'd1,
        OP_READ    = 2'd2,
        OP_NONE    = 2'd3
    } opcode_t;

    localparam logic KIND_DONE = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic occ_wr;
        logic rd_issue;
        logic out_far;
        logic out_read;
        logic out_done;
        logic start;
        logic ld_issue;
        logic ld_write;
        logic b_init;
        logic b_issue;
        logic b_fq;
        logic b_skip;
        logic b_first;
        logic b_venv;
        logic b_vlb;
        logic b_fv;
        logic b_pop;
        logic b_push;
        logic q_start;
        logic q_bnd;
        logic q_kinc;
        logic q_env;
        logic q_lb;
        logic q_write;
        logic q_inf;
        logic line_next;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic in_range;
        logic q_last;
        logic line_last;
        logic pass_col;
        logic lb_inf;
        logic cnt_zero;
        logic pop;
        logic k_has_next;
        logic k_adv;
    } sts_t;

endpackage

>>> sv/sedg_ctrl.sv
module sedg_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  sedg_pkg::opcode_t   in_op,
    output logic                in_ready,
    input  sedg_pkg::sts_t      sts,
    output sedg_pkg::cmd_t      cmd
);

    typedef enum logic [18:0] {
        S_IDLE     = 19'b0000000000000000001,
        S_RD       = 19'b0000000000000000010,
        S_LD_ISSUE = 19'b0000000000000000100,
        S_LD_WR    = 19'b0000000000000001000,
        S_B_INIT   = 19'b0000000000000010000,
        S_B_ISSUE  = 19'b0000000000000100000,
        S_B_CHK    = 19'b0000000000001000000,
        S_B_VENV   = 19'b0000000000010000000,
        S_B_VLB    = 19'b0000000000100000000,
        S_B_FV     = 19'b0000000001000000000,
        S_B_CMP    = 19'b0000000010000000000,
        S_Q_INIT   = 19'b0000000100000000000,
        S_Q_INF    = 19'b0000001000000000000,
        S_Q_K      = 19'b0000010000000000000,
        S_Q_KC     = 19'b0000100000000000000,
        S_Q_LB     = 19'b0001000000000000000,
        S_Q_WR     = 19'b0010000000000000000,
        S_LINE_END = 19'b0100000000000000000,
        S_DONE     = 19'b1000000000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign in_ready = (state_reg == S_IDLE) && sts.out_free;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (in_op)
                        sedg_pkg::OP_WRITE:
                        begin
                            cmd.occ_wr = sts.in_range;
                        end
                        sedg_pkg::OP_COMPUTE:
                        begin
                            cmd.start  = 1'b1;
                            state_next = S_LD_ISSUE;
                        end
                        sedg_pkg::OP_READ:
                        begin
                            if (sts.in_range)
                            begin
                                cmd.rd_issue = 1'b1;
                                state_next   = S_RD;
                            end
                            else
                            begin
                                cmd.out_far = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RD:
            begin
                cmd.out_read = 1'b1;
                state_next   = S_IDLE;
            end
            S_LD_ISSUE:
            begin
                cmd.ld_issue = 1'b1;
                state_next   = S_LD_WR;
            end
            S_LD_WR:
            begin
                cmd.ld_write = 1'b1;
                state_next   = sts.q_last ? S_B_INIT : S_LD_ISSUE;
            end
            S_B_INIT:
            begin
                cmd.b_init = 1'b1;
                state_next = S_B_ISSUE;
            end
            S_B_ISSUE:
            begin
                cmd.b_issue = 1'b1;
                state_next  = S_B_CHK;
            end
            S_B_CHK:
            begin
                if (sts.lb_inf)
                begin
                    cmd.b_skip = 1'b1;
                    state_next = sts.q_last ? S_Q_INIT : S_B_ISSUE;
                end
                else if (sts.cnt_zero)
                begin
                    cmd.b_first = 1'b1;
                    state_next  = sts.q_last ? S_Q_INIT : S_B_ISSUE;
                end
                else
                begin
                    cmd.b_fq   = 1'b1;
                    state_next = S_B_VENV;
                end
            end
            S_B_VENV:
            begin
                cmd.b_venv = 1'b1;
                state_next = S_B_VLB;
            end
            S_B_VLB:
            begin
                cmd.b_vlb  = 1'b1;
                state_next = S_B_FV;
            end
            S_B_FV:
            begin
                cmd.b_fv   = 1'b1;
                state_next = S_B_CMP;
            end
            S_B_CMP:
            begin
                if (sts.pop)
                begin
                    cmd.b_pop  = 1'b1;
                    state_next = S_B_VENV;
                end
                else
                begin
                    cmd.b_push = 1'b1;
                    state_next = sts.q_last ? S_Q_INIT : S_B_ISSUE;
                end
            end
            S_Q_INIT:
            begin
                cmd.q_start = 1'b1;
                state_next  = sts.cnt_zero ? S_Q_INF : S_Q_K;
            end
            S_Q_INF:
            begin
                cmd.q_inf  = 1'b1;
                state_next = sts.q_last ? S_LINE_END : S_Q_INF;
            end
            S_Q_K:
            begin
                if (sts.k_has_next)
                begin
                    cmd.q_bnd  = 1'b1;
                    state_next = S_Q_KC;
                end
                else
                begin
                    cmd.q_env  = 1'b1;
                    state_next = S_Q_LB;
                end
            end
            S_Q_KC:
            begin
                if (sts.k_adv)
                begin
                    cmd.q_kinc = 1'b1;
                    state_next = S_Q_K;
                end
                else
                begin
                    cmd.q_env  = 1'b1;
                    state_next = S_Q_LB;
                end
            end
            S_Q_LB:
            begin
                cmd.q_lb   = 1'b1;
                state_next = S_Q_WR;
            end
            S_Q_WR:
            begin
                cmd.q_write = 1'b1;
                state_next  = sts.q_last ? S_LINE_END : S_Q_K;
            end
            S_LINE_END:
            begin
                cmd.line_next = 1'b1;
                state_next    = (sts.line_last && sts.pass_col) ? S_DONE : S_LD_ISSUE;
            end
            S_DONE:
            begin
                cmd.out_done = 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> sv/sedg_datapath.sv
module sedg_datapath
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr,
    input  logic                               cfg_idx,
    input  logic [sedg_pkg::DIM_W-1:0]         cfg_value,
    input  logic [sedg_pkg::COORD_W-1:0]       in_col,
    input  logic [sedg_pkg::COORD_W-1:0]       in_row,
    input  logic                               in_occ,
    input  logic                               out_ready,
    input  sedg_pkg::cmd_t                     cmd,
    output sedg_pkg::sts_t                     sts,
    output logic                               out_valid,
    output logic                               out_kind,
    output logic [sedg_pkg::VAL_W-1:0]         out_dist,
    output logic                               out_noobs
);

    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(CELLS);
    localparam int LIM_W = (MAX_WIDTH  < sedg_pkg::LINE_MAX) ? MAX_WIDTH  : sedg_pkg::LINE_MAX;
    localparam int LIM_H = (MAX_HEIGHT < sedg_pkg::LINE_MAX) ? MAX_HEIGHT : sedg_pkg::LINE_MAX;
    localparam int CW    = sedg_pkg::COORD_W;
    localparam int DW    = sedg_pkg::DIM_W;
    localparam int EW    = sedg_pkg::ENT_W;
    localparam int PW    = sedg_pkg::PROD_W;

    logic [DW-1:0] width_reg, height_reg;
    logic [DW-1:0] w_eff, h_eff, n_len, n_lines;

    logic          pass_reg;
    logic [CW-1:0] line_reg;
    logic [DW-1:0] q_reg;
    logic [DW-1:0] cnt_reg;
    logic [CW-1:0] k_reg;
    logic          any_reg;
    logic          noobs_reg;

    logic          occ_mem  [CELLS];
    logic [EW-1:0] rp_mem   [CELLS];
    logic [EW-1:0] dist_mem [CELLS];
    logic [EW-1:0] lb_mem   [sedg_pkg::LINE_MAX];
    logic [CW-1:0] env_mem  [sedg_pkg::LINE_MAX];
    logic signed [sedg_pkg::NUM_W-1:0] bn_mem [sedg_pkg::LINE_MAX];
    logic [sedg_pkg::DEN_W-1:0]        bd_mem [sedg_pkg::LINE_MAX];

    logic          occ_q;
    logic [EW-1:0] rp_q, dist_q, lb_q;
    logic [CW-1:0] env_q;
    logic signed [sedg_pkg::NUM_W-1:0] bn_q;
    logic [sedg_pkg::DEN_W-1:0]        bd_q;

    logic [15:0]   sq_reg, vsq_reg;
    logic [EW-1:0] fq_reg;
    logic [CW-1:0] v_reg;
    logic signed [sedg_pkg::NUM_W-1:0] sn_reg;
    logic [sedg_pkg::DEN_W-1:0]        sd_reg;

    logic [AW-1:0] in_addr, line_addr;
    logic [CW-1:0] yy, xx, q8, cnt_m1, k_p1, lb_ra, env_ra, bnd_ra;
    logic [EW-1:0] ld_data, fv, d_sum, dest_data;
    logic          dest_wr;
    logic signed [PW-1:0] p_l, p_r;
    logic [17:0]   qb;
    logic signed [9:0]  diff;
    logic signed [19:0] dsq;
    logic [sedg_pkg::VAL_W-1:0] d_sat;

    // Effective dimensions are clamped to 1..min(max, 256).
    always_comb
    begin
        if (width_reg == '0)
            w_eff = DW'(1);
        else if (width_reg > DW'(LIM_W))
            w_eff = DW'(LIM_W);
        else
            w_eff = width_reg;
        if (height_reg == '0)
            h_eff = DW'(1);
        else if (height_reg > DW'(LIM_H))
            h_eff = DW'(LIM_H);
        else
            h_eff = height_reg;
    end

    assign n_len   = pass_reg ? h_eff : w_eff;
    assign n_lines = pass_reg ? w_eff : h_eff;
    assign q8      = q_reg[CW-1:0];
    assign yy      = pass_reg ? q8 : line_reg;
    assign xx      = pass_reg ? line_reg : q8;
    assign in_addr   = AW'(AW'(in_row) * AW'(MAX_WIDTH) + AW'(in_col));
    assign line_addr = AW'(AW'(yy) * AW'(MAX_WIDTH) + AW'(xx));

    assign cnt_m1 = CW'(cnt_reg - DW'(1));
    assign k_p1   = CW'(k_reg + CW'(1));
    assign lb_ra  = cmd.b_issue ? q8 : env_q;
    assign env_ra = cmd.b_venv ? cnt_m1 : k_reg;
    assign bnd_ra = cmd.b_venv ? cnt_m1 : k_p1;

    assign ld_data = pass_reg ? rp_q : (occ_q ? '0 : sedg_pkg::ENT_INF);
    assign fv      = {1'b0, lb_q[sedg_pkg::VAL_W-1:0]} + EW'(vsq_reg);

    assign p_l = PW'(sn_reg) * PW'($signed({1'b0, bd_q}));
    assign p_r = PW'(bn_q) * PW'($signed({1'b0, sd_reg}));
    assign qb  = 18'(q8) * 18'(bd_q);

    assign diff  = $signed({2'b00, q8}) - $signed({2'b00, v_reg});
    assign dsq   = 20'(diff) * 20'(diff);
    assign d_sum = EW'(dsq) + {1'b0, lb_q[sedg_pkg::VAL_W-1:0]};
    assign d_sat = (d_sum > EW'(sedg_pkg::VAL_MAX)) ? sedg_pkg::VAL_MAX
                                                    : d_sum[sedg_pkg::VAL_W-1:0];

    assign dest_wr   = cmd.q_write || cmd.q_inf;
    assign dest_data = cmd.q_inf ? sedg_pkg::ENT_INF : {1'b0, d_sat};

    always_comb
    begin
        sts.out_free   = !out_valid || out_ready;
        sts.in_range   = ({1'b0, in_col} < w_eff) && ({1'b0, in_row} < h_eff);
        sts.q_last     = (q_reg == n_len - DW'(1));
        sts.line_last  = ({1'b0, line_reg} == n_lines - DW'(1));
        sts.pass_col   = pass_reg;
        sts.lb_inf     = lb_q[EW-1];
        sts.cnt_zero   = (cnt_reg == '0);
        sts.pop        = (cnt_reg > DW'(1)) && (p_l <= p_r);
        sts.k_has_next = ((DW'(k_reg) + DW'(1)) < cnt_reg);
        sts.k_adv      = bn_q < $signed({1'b0, qb});
    end

    always_ff @(posedge clk)
    begin
        if (cmd.occ_wr)
            occ_mem[in_addr] <= in_occ;
        if (cmd.ld_issue)
            occ_q <= occ_mem[line_addr];
    end

    always_ff @(posedge clk)
    begin
        if (dest_wr && !pass_reg)
            rp_mem[line_addr] <= dest_data;
        if (cmd.ld_issue)
            rp_q <= rp_mem[line_addr];
    end

    always_ff @(posedge clk)
    begin
        if (dest_wr && pass_reg)
            dist_mem[line_addr] <= dest_data;
        if (cmd.rd_issue)
            dist_q <= dist_mem[in_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_write)
            lb_mem[q8] <= ld_data;
        if (cmd.b_issue || cmd.b_vlb || cmd.q_lb)
            lb_q <= lb_mem[lb_ra];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.b_first)
            env_mem[0] <= q8;
        else if (cmd.b_push)
            env_mem[cnt_reg[CW-1:0]] <= q8;
        if (cmd.b_venv || cmd.q_env)
            env_q <= env_mem[env_ra];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.b_push)
        begin
            bn_mem[cnt_reg[CW-1:0]] <= sn_reg;
            bd_mem[cnt_reg[CW-1:0]] <= sd_reg;
        end
        if (cmd.b_venv || cmd.q_bnd)
        begin
            bn_q <= bn_mem[bnd_ra];
            bd_q <= bd_mem[bnd_ra];
        end
    end

    // Envelope arithmetic registers.
    always_ff @(posedge clk)
    begin
        if (cmd.b_issue)
            sq_reg <= 16'(q8) * 16'(q8);
        if (cmd.b_fq)
            fq_reg <= {1'b0, lb_q[sedg_pkg::VAL_W-1:0]} + EW'(sq_reg);
        if (cmd.b_vlb || cmd.q_lb)
            v_reg <= env_q;
        if (cmd.b_vlb)
            vsq_reg <= 16'(env_q) * 16'(env_q);
        if (cmd.b_fv)
        begin
            sn_reg <= $signed({1'b0, fq_reg}) - $signed({1'b0, fv});
            sd_reg <= {1'b0, CW'(q8 - v_reg), 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DW'(256);
            height_reg <= DW'(256);
            pass_reg   <= 1'b0;
            line_reg   <= '0;
            q_reg      <= '0;
            cnt_reg    <= '0;
            k_reg      <= '0;
            any_reg    <= 1'b0;
            noobs_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                if (cfg_idx == sedg_pkg::REG_WIDTH)
                    width_reg <= cfg_value;
                else
                    height_reg <= cfg_value;
            end
            if (cmd.start)
            begin
                pass_reg <= 1'b0;
                line_reg <= '0;
                q_reg    <= '0;
                cnt_reg  <= '0;
                any_reg  <= 1'b0;
            end
            if (cmd.ld_write && !pass_reg && occ_q)
                any_reg <= 1'b1;
            if (cmd.ld_write || cmd.b_skip || cmd.b_first || cmd.b_push
                || cmd.q_write || cmd.q_inf)
                q_reg <= q_reg + DW'(1);
            if (cmd.b_init || cmd.q_start || cmd.line_next)
                q_reg <= '0;
            if (cmd.b_init)
                cnt_reg <= '0;
            if (cmd.b_first)
                cnt_reg <= DW'(1);
            if (cmd.b_push)
                cnt_reg <= cnt_reg + DW'(1);
            if (cmd.b_pop)
                cnt_reg <= cnt_reg - DW'(1);
            if (cmd.q_start)
                k_reg <= '0;
            if (cmd.q_kinc)
                k_reg <= k_reg + CW'(1);
            if (cmd.line_next)
            begin
                if (sts.line_last)
                begin
                    pass_reg <= 1'b1;
                    line_reg <= '0;
                end
                else
                begin
                    line_reg <= line_reg + CW'(1);
                end
            end
            if (cmd.out_done)
                noobs_reg <= !any_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (cmd.out_done || cmd.out_read || cmd.out_far)
        begin
            out_valid <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_done)
        begin
            out_kind  <= sedg_pkg::KIND_DONE;
            out_dist  <= '0;
            out_noobs <= !any_reg;
        end
        else if (cmd.out_read)
        begin
            out_kind  <= sedg_pkg::KIND_READ;
            out_dist  <= dist_q[EW-1] ? sedg_pkg::VAL_MAX : dist_q[sedg_pkg::VAL_W-1:0];
            out_noobs <= noobs_reg;
        end
        else if (cmd.out_far)
        begin
            out_kind  <= sedg_pkg::KIND_READ;
            out_dist  <= sedg_pkg::VAL_MAX;
            out_noobs <= noobs_reg;
        end
    end

endmodule

>>> sv/squared_euclidean_distance_grid.sv
// Channel   Direction  Signals                          Contents
// s_*       in         s_tvalid s_tready s_tdata s_tuser  write, compute and read commands
// m_*       out        m_tvalid m_tready m_tdata m_tuser  compute done and read results
// cfg_*     in         cfg_valid cfg_ready cfg_index cfg_data  width and height in use
//
// A write completes in the cycle it is accepted; an in-range read passes through state S_RD and the
// registered distance memory port. A compute walks every row and then every column; each line of
// n cells is loaded, then the envelope is built cell by cell with pops as needed, then results are
// written cell by cell with boundary steps (one cycle per cell when the line holds no finite
// cell).
// Reset clears the controller, counters and flags; the grid memories hold nothing
// defined until written. Commands are held off while a result waits and is not taken.
module squared_euclidean_distance_grid
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // col[7:0], row[15:8], occupied[16], zero fill
    input  logic [1:0]  s_tuser,    // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // squared_distance[16:0], no_obstacle[17], zero fill
    output logic [0:0]  m_tuser,    // kind[0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_data
);

    sedg_pkg::cmd_t             cmd;
    sedg_pkg::sts_t             sts;
    logic                       out_kind;
    logic                       out_noobs;
    logic [sedg_pkg::VAL_W-1:0] out_dist;

    assign cfg_ready = 1'b1;

    sedg_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_op    (sedg_pkg::opcode_t'(s_tuser)),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sedg_datapath
    #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_idx   (cfg_index),
        .cfg_value (cfg_data),
        .in_col    (s_tdata[7:0]),
        .in_row    (s_tdata[15:8]),
        .in_occ    (s_tdata[16]),
        .out_ready (m_tready),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (m_tvalid),
        .out_kind  (out_kind),
        .out_dist  (out_dist),
        .out_noobs (out_noobs)
    );

    assign m_tdata = {6'b0, out_noobs, out_dist};
    assign m_tuser = out_kind;

    a_compute_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == sedg_pkg::OP_COMPUTE) |=> !s_tready)
        else $error("input accepted right after a compute command");

    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0] == sedg_pkg::KIND_DONE) |-> (m_tdata[16:0] == 17'd0))
        else $error("compute done result carries a nonzero distance");

    a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.out_done, cmd.out_read, cmd.out_far}))
        else $error("more than one result loaded in a cycle");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_done || cmd.out_read || cmd.out_far) |-> (!m_tvalid || m_tready))
        else $error("result register overwritten while a result waits");

endmodule
